// ===== rtl/u2a_pkg.sv =====
// Shared types, codes and character tables for the unsigned-to-ASCII converter.
// No dependencies; imported by u2a_ctrl, u2a_dpath and unsigned_to_ascii_radix_top.
package u2a_pkg;

   localparam int VALUE_W            = 64;   // request value port width
   localparam int VALUE_BITS_DEFAULT = 64;   // bits of the value actually used
   localparam int CHAR_W             = 7;
   localparam int DIGIT_W            = 4;

   // radix modes
   localparam logic [1:0] MODE_DEC  = 2'd0;
   localparam logic [1:0] MODE_OCT  = 2'd1;
   localparam logic [1:0] MODE_HEXL = 2'd2;
   localparam logic [1:0] MODE_HEXU = 2'd3;

   // length selects (any other code keeps 32 bits)
   localparam logic [1:0] LSEL_LONG  = 2'd1;
   localparam logic [1:0] LSEL_SHORT = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_X_LOWER = 7'h78;
   localparam logic [CHAR_W-1:0] CHAR_X_UPPER = 7'h58;

   localparam logic [CHAR_W-1:0] LOWER_DIGITS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66};
   localparam logic [CHAR_W-1:0] UPPER_DIGITS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_PREFIX,
      ST_DIGIT
   } state_type;

   typedef struct packed {
      logic load;          // capture request
      logic dabble;        // one shift-add-3 step
      logic shift_digit;   // drop top digit
      logic next_prefix;   // advance prefix
      logic show_prefix;   // output mux selects prefix char
   } cmd_type;

   typedef struct packed {
      logic decimal;
      logic conv_done;
      logic top_zero;
      logic one_left;
      logic prefix_pending;
      logic prefix_last;
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] c;
      c = upper ? UPPER_DIGITS[d] : LOWER_DIGITS[d];
      return c;
   endfunction

endpackage

// ===== rtl/unsigned_to_ascii_radix_top.sv =====
// Channel    Direction  Handshake             Payload
// req        in         req_valid/req_stall   req_value, req_mode, req_length_select, req_alt_form
// rsp        out        rsp_valid/rsp_stall   rsp_char_out, rsp_last_char
//
// One request at a time. After the accept, decimal values take one shift-add-3
// step per value bit (16, 32 or VALUE_BITS bits by length select); then leading
// zero digits are dropped, then the prefix, if any, and the characters go out.
// The shift-add-3 loop and the one-digit-per-cycle zero skip set the latency.
// Reset is synchronous and returns the controller to idle; a stalled response
// holds its character and freezes the datapath.
// Top level: joins u2a_ctrl and u2a_dpath. Depends on u2a_pkg.
module unsigned_to_ascii_radix_top import u2a_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_length_select,
   input  logic               req_alt_form,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_last_char
);

   cmd_type    cmd;
   status_type status;

   u2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   u2a_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_value),
      .req_mode          (req_mode),
      .req_length_select (req_length_select),
      .req_alt_form      (req_alt_form),
      .cmd               (cmd),
      .status            (status),
      .rsp_char_out      (rsp_char_out),
      .rsp_last_char     (rsp_last_char)
   );

endmodule

// ===== rtl/u2a_ctrl.sv =====
// Controller FSM: sequences capture, binary-to-BCD steps, leading-zero skip
// and character output. Depends on u2a_pkg.
module u2a_ctrl import u2a_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (!status.decimal || status.conv_done) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!(status.top_zero && !status.one_left)) begin
               state_in = status.prefix_pending ? ST_PREFIX : ST_DIGIT;
            end
         end
         ST_PREFIX: begin
            if (!rsp_stall && status.prefix_last) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (!rsp_stall && status.one_left) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_PREFIX) || (state_ff == ST_DIGIT);
      unique case (state_ff)
         ST_IDLE:    cmd.load = req_valid;
         ST_CONVERT: cmd.dabble = status.decimal;
         ST_SKIP:    cmd.shift_digit = status.top_zero && !status.one_left;
         ST_PREFIX: begin
            cmd.show_prefix = 1'b1;
            cmd.next_prefix = !rsp_stall;
         end
         ST_DIGIT:   cmd.shift_digit = !rsp_stall;
         default:    cmd = '0;
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONVERT))
      else $error("accepted request did not start conversion");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && !rsp_stall && status.one_left) |=> (state_ff == ST_IDLE))
      else $error("final character did not return to idle");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while characters pending");

endmodule

// ===== rtl/u2a_dpath.sv =====
// Datapath: value truncation, shift-add-3 BCD conversion, digit register,
// prefix counter and character mux. Depends on u2a_pkg.
module u2a_dpath import u2a_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_length_select,
   input  logic               req_alt_form,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_last_char
);

   // octal needs the most digits of any radix
   localparam int NDIG   = (VALUE_BITS + 2) / 3;
   localparam int CNT_W  = $clog2(NDIG + 1);
   localparam int ITER_W = $clog2(VALUE_BITS + 1);
   localparam int W32    = (VALUE_BITS < 32) ? VALUE_BITS : 32;

   logic [DIGIT_W-1:0]    digits_ff [NDIG];
   logic [DIGIT_W-1:0]    digits_in [NDIG];
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [1:0]            mode_ff, mode_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [1:0]            pre_ff, pre_in;

   logic [VALUE_BITS-1:0] vfull, num, aligned;
   logic [ITER_W-1:0]     iter_load;
   logic [NDIG*3-1:0]     oct_pad;
   logic [NDIG*4-1:0]     hex_pad;
   logic [DIGIT_W-1:0]    load_digits [NDIG];
   logic [DIGIT_W-1:0]    adj [NDIG];
   logic [1:0]            pre_load;
   logic [CHAR_W-1:0]     prefix_char;

   // truncation; decimal operand is left-aligned so its MSB shifts out first
   always_comb begin
      vfull = req_value[VALUE_BITS-1:0];
      unique case (req_length_select)
         LSEL_LONG: begin
            num       = vfull;
            aligned   = vfull;
            iter_load = ITER_W'(VALUE_BITS);
         end
         LSEL_SHORT: begin
            num       = vfull & ~({VALUE_BITS{1'b1}} << 16);
            aligned   = vfull << (VALUE_BITS - 16);
            iter_load = ITER_W'(16);
         end
         default: begin
            num       = vfull & ~({VALUE_BITS{1'b1}} << W32);
            aligned   = vfull << (VALUE_BITS - W32);
            iter_load = ITER_W'(W32);
         end
      endcase
      oct_pad = (NDIG*3)'(num);
      hex_pad = (NDIG*4)'(num);
      for (int i = 0; i < NDIG; i++) begin
         if (req_mode == MODE_DEC) begin
            load_digits[i] = '0;
         end else if (req_mode == MODE_OCT) begin
            load_digits[i] = {1'b0, oct_pad[3*i +: 3]};
         end else begin
            load_digits[i] = hex_pad[4*i +: 4];
         end
      end
      // prefix test uses the value before the length cut
      if (req_alt_form && (vfull != '0)) begin
         if (req_mode == MODE_OCT) begin
            pre_load = 2'd1;
         end else if (req_mode == MODE_DEC) begin
            pre_load = 2'd0;
         end else begin
            pre_load = 2'd2;
         end
      end else begin
         pre_load = 2'd0;
      end
   end

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
   end

   always_comb begin
      digits_in = digits_ff;
      bin_in    = bin_ff;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      iter_in   = iter_ff;
      pre_in    = pre_ff;
      priority if (cmd.load) begin
         digits_in = load_digits;
         bin_in    = aligned;
         mode_in   = req_mode;
         cnt_in    = CNT_W'(NDIG);
         iter_in   = iter_load;
         pre_in    = pre_load;
      end else if (cmd.dabble) begin
         digits_in[0] = {adj[0][2:0], bin_ff[VALUE_BITS-1]};
         for (int i = 1; i < NDIG; i++) begin
            digits_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
         bin_in  = bin_ff << 1;
         iter_in = iter_ff - ITER_W'(1);
      end else if (cmd.shift_digit) begin
         for (int i = NDIG - 1; i > 0; i--) begin
            digits_in[i] = digits_ff[i-1];
         end
         digits_in[0] = '0;
         cnt_in       = cnt_ff - CNT_W'(1);
      end else if (cmd.next_prefix) begin
         pre_in = pre_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         iter_ff <= '0;
         pre_ff  <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         iter_ff <= iter_in;
         pre_ff  <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      bin_ff    <= bin_in;
      mode_ff   <= mode_in;
   end

   always_comb begin
      status.decimal        = (mode_ff == MODE_DEC);
      status.conv_done      = (iter_ff == ITER_W'(1));
      status.top_zero       = (digits_ff[NDIG-1] == '0);
      status.one_left       = (cnt_ff == CNT_W'(1));
      status.prefix_pending = (pre_ff != 2'd0);
      status.prefix_last    = (pre_ff == 2'd1);
   end

   always_comb begin
      if (pre_ff == 2'd2 || mode_ff == MODE_OCT) begin
         prefix_char = CHAR_ZERO;
      end else if (mode_ff == MODE_HEXL) begin
         prefix_char = CHAR_X_LOWER;
      end else begin
         prefix_char = CHAR_X_UPPER;
      end
      rsp_char_out  = cmd.show_prefix ? prefix_char
                                      : digit_char(digits_ff[NDIG-1], mode_ff == MODE_HEXU);
      rsp_last_char = !cmd.show_prefix && status.one_left;
   end

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_digit |-> (cnt_ff != '0))
      else $error("digit shift with no digits left");

   a_dabble_count: assert property (@(posedge clock) disable iff (reset)
      cmd.dabble |-> (iter_ff != '0))
      else $error("conversion step past bit count");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NDIG))
      else $error("digit count out of range");

   a_prefix_range: assert property (@(posedge clock) disable iff (reset)
      cmd.next_prefix |-> (pre_ff == 2'd1 || pre_ff == 2'd2))
      else $error("prefix advance with no prefix pending");

endmodule
